FILE: rtl/bpra_pkg.sv
// ----------------------------------------------------------------------------
// bpra_pkg
// Shared types and constants for the bitmap page run allocator: field widths,
// beat layout, operation and status codes, and the word scan result bundle.
// ----------------------------------------------------------------------------
package bpra_pkg;

  // Default geometry of the tracked window
  localparam int unsigned DEF_TRACKED_PAGES = 4096;
  localparam int unsigned DEF_FIRST_PAGE    = 1024;
  localparam int unsigned DEF_WORD_BITS     = 32;

  // Field widths
  localparam int PAGE_W  = 20;
  localparam int COUNT_W = 13;
  // Page index arithmetic: holds page + count and window end without wrap
  localparam int IDX_W   = 22;

  // Input beat layout: start_page low, page_count above, zero padded
  localparam int IN_DATA_W   = 40;
  localparam int IN_START_LO = 0;
  localparam int IN_COUNT_LO = PAGE_W;

  // Output beat layout: run_start, zero padded
  localparam int OUT_DATA_W = 24;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STATUS_DONE       = 2'd0,
    STATUS_NO_SPACE   = 2'd1,
    STATUS_ZERO_COUNT = 2'd2
  } status_t;

  // Result of scanning one bitmap word for a free run
  typedef struct packed {
    logic               found;      // run of the requested length ends here
    logic               start_here; // that run starts inside this word
    logic               any_zero;   // word holds at least one used page
    logic [COUNT_W-1:0] run_out;    // free pages ending at the word's top bit
  } scan_res_t;

endpackage

FILE: rtl/bpra_word_scan.sv
// ----------------------------------------------------------------------------
// bpra_word_scan
// Searches one bitmap word for the lowest bit at which a free run of the
// requested length completes, taking the run carried in from lower words.
// ----------------------------------------------------------------------------
module bpra_word_scan #(
  parameter int unsigned WORD_BITS = bpra_pkg::DEF_WORD_BITS
) (
  input  logic [WORD_BITS-1:0]          word_i,
  input  logic [bpra_pkg::COUNT_W-1:0]  run_in,
  input  logic [bpra_pkg::COUNT_W-1:0]  count,
  output logic [$clog2(WORD_BITS)-1:0]  hit_idx,
  output bpra_pkg::scan_res_t           res
);

  localparam int HIT_W = $clog2(WORD_BITS);
  localparam int RUN_W = bpra_pkg::COUNT_W + 1;

  logic [WORD_BITS-1:0] hit_vec;

  // Per bit: the window of count bits ending here is all free, and the run
  // carried from below covers whatever part of the window lies under bit 0
  for (genvar j = 0; j < WORD_BITS; j++) begin : g_bit
    localparam logic [WORD_BITS-1:0] LOW_MASK = {WORD_BITS{1'b1}} >> (WORD_BITS - 1 - j);
    logic [WORD_BITS-1:0] win_mask;
    logic                 win_free;
    logic [RUN_W-1:0]     reach;

    assign win_mask   = LOW_MASK & ~(LOW_MASK >> count);
    assign win_free   = (~word_i & win_mask) == '0;
    assign reach      = RUN_W'(run_in) + RUN_W'(j + 1);
    assign hit_vec[j] = win_free && (reach >= RUN_W'(count));
  end

  // Pick the lowest hit, find the top used page, summarize
  always_comb begin
    int hz;
    hz      = 0;
    hit_idx = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (hit_vec[j]) begin
        hit_idx = HIT_W'(j);
      end
    end
    for (int j = 0; j < WORD_BITS; j++) begin
      if (!word_i[j]) begin
        hz = j;
      end
    end
    res.found      = |hit_vec;
    res.start_here = RUN_W'(count) <= (RUN_W'(hit_idx) + RUN_W'(1));
    res.any_zero   = ~&word_i;
    if (&word_i) begin
      res.run_out = bpra_pkg::COUNT_W'(RUN_W'(run_in) + RUN_W'(WORD_BITS));
    end else begin
      res.run_out = bpra_pkg::COUNT_W'(WORD_BITS - 1 - hz);
    end
  end

endmodule

FILE: rtl/bitmap_page_run_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_page_run_allocator
// First-fit page frame allocator over a free-page bitmap held in one RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry an operation on in_tuser (allocate or free) and a start
//   page and page count on in_tdata. Every input beat yields one output beat:
//   status on out_tuser and the first page of an allocated run on out_tdata.
//   One operation is in flight at a time; in_tready is high only while idle.
// Sequence (MAP_WORDS = bitmap words, one word per cycle through the RAM port);
//   in_tready rises again with out_tvalid:
//   zero-count allocate, or free that misses the window: straight to the response.
//   free: one pass from word 0 up to the last word it touches, then the response.
//   allocate: a scan over at most MAP_WORDS words until the run is found,
//   then a read-modify-write pass over the words of the run, then the response.
// Reset: the RAM is swept to all zero (every page in use), one word per
//   cycle; no input beat is taken until the sweep is done.
// Stall: a finished result waits in the output register; the next operation
//   may be accepted and run, and holds in its response step until the
//   previous result has been taken.
// ----------------------------------------------------------------------------
module bitmap_page_run_allocator #(
  parameter int unsigned TRACKED_PAGES = bpra_pkg::DEF_TRACKED_PAGES,
  parameter int unsigned FIRST_PAGE    = bpra_pkg::DEF_FIRST_PAGE,
  parameter int unsigned WORD_BITS     = bpra_pkg::DEF_WORD_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [19:0] start_page, [32:20] page_count, [39:33] zero
  input  logic [bpra_pkg::IN_DATA_W-1:0]   in_tdata,
  // [0] opcode
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [19:0] run_start, [23:20] zero
  output logic [bpra_pkg::OUT_DATA_W-1:0]  out_tdata,
  // [1:0] status
  output logic [1:0]                       out_tuser
);

  localparam int unsigned MAP_WORDS = (TRACKED_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int ADDR_W  = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int WCNT_W  = $clog2(MAP_WORDS + 1);
  localparam int HIT_W   = $clog2(WORD_BITS);
  localparam int OFF_W   = $clog2(WORD_BITS + 1);
  localparam int IDX_W   = bpra_pkg::IDX_W;
  localparam int PAGE_W  = bpra_pkg::PAGE_W;
  localparam int COUNT_W = bpra_pkg::COUNT_W;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_APPLY,
    S_RESP
  } state_t;

  state_t                 state_r;
  bpra_pkg::op_t          op_r;
  bpra_pkg::status_t      status_r;
  logic [COUNT_W-1:0]     count_r;
  logic [IDX_W-1:0]       lo_r;
  logic [IDX_W-1:0]       hi_r;
  logic [WCNT_W-1:0]      issue_w_r;
  logic [IDX_W-1:0]       issue_base_r;
  logic                   pv_r;
  logic [ADDR_W-1:0]      proc_w_r;
  logic [IDX_W-1:0]       proc_base_r;
  logic [COUNT_W-1:0]     run_r;
  logic [WCNT_W-1:0]      cs_w_r;
  logic [IDX_W-1:0]       cs_base_r;
  logic                   out_tvalid_r;
  bpra_pkg::status_t      out_status_r;
  logic [PAGE_W-1:0]      out_run_r;

  logic [WORD_BITS-1:0]   map_mem [MAP_WORDS];
  logic [WORD_BITS-1:0]   rd_data_r;
  logic                   mem_re;
  logic [ADDR_W-1:0]      mem_raddr;
  logic                   mem_we;
  logic [ADDR_W-1:0]      mem_waddr;
  logic [WORD_BITS-1:0]   mem_wdata;

  logic                   in_acc;
  bpra_pkg::op_t          in_op;
  logic [IDX_W-1:0]       in_start;
  logic [COUNT_W-1:0]     in_count;
  logic [IDX_W-1:0]       in_end;
  logic [IDX_W-1:0]       free_lo;
  logic [IDX_W-1:0]       free_hi;
  logic                   issue_ok;
  logic [HIT_W-1:0]       hit_idx;
  bpra_pkg::scan_res_t    scan;
  logic [IDX_W-1:0]       hit_first;
  logic [IDX_W-1:0]       lo_diff;
  logic [IDX_W-1:0]       hi_diff;
  logic [OFF_W-1:0]       lo_off;
  logic [OFF_W-1:0]       hi_off;
  logic [WORD_BITS-1:0]   run_mask;

  // Unpack the input beat
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_op     = bpra_pkg::op_t'(in_tuser);
  assign in_start  = IDX_W'(in_tdata[bpra_pkg::IN_START_LO +: PAGE_W]);
  assign in_count  = in_tdata[bpra_pkg::IN_COUNT_LO +: COUNT_W];
  assign in_end    = in_start + IDX_W'(in_count);

  // Clip a freed run to the window, as offsets into the bitmap
  always_comb begin
    if (in_start < IDX_W'(FIRST_PAGE)) begin
      free_lo = '0;
    end else begin
      free_lo = in_start - IDX_W'(FIRST_PAGE);
    end
    if (in_end >= IDX_W'(FIRST_PAGE + TRACKED_PAGES)) begin
      free_hi = IDX_W'(TRACKED_PAGES);
    end else if (in_end < IDX_W'(FIRST_PAGE)) begin
      free_hi = '0;
    end else begin
      free_hi = in_end - IDX_W'(FIRST_PAGE);
    end
  end

  // Issue the next word read while the pass has words left
  always_comb begin
    unique case (state_r)
      S_SCAN:  issue_ok = issue_w_r < WCNT_W'(MAP_WORDS);
      S_APPLY: issue_ok = (issue_w_r < WCNT_W'(MAP_WORDS)) && (issue_base_r < hi_r);
      default: issue_ok = 1'b0;
    endcase
  end

  assign mem_re    = issue_ok;
  assign mem_raddr = issue_w_r[ADDR_W-1:0];

  // Scan the word that came back from the RAM
  bpra_word_scan #(
    .WORD_BITS (WORD_BITS)
  ) u_scan (
    .word_i  (rd_data_r),
    .run_in  (run_r),
    .count   (count_r),
    .hit_idx (hit_idx),
    .res     (scan)
  );

  assign hit_first = proc_base_r + IDX_W'(hit_idx) + IDX_W'(1) - IDX_W'(count_r);

  // Bits of the current word that fall inside [lo_r, hi_r)
  assign lo_diff = lo_r - proc_base_r;
  assign hi_diff = hi_r - proc_base_r;

  always_comb begin
    if (lo_r <= proc_base_r) begin
      lo_off = '0;
    end else if (lo_diff >= IDX_W'(WORD_BITS)) begin
      lo_off = OFF_W'(WORD_BITS);
    end else begin
      lo_off = OFF_W'(lo_diff);
    end
    if (hi_r <= proc_base_r) begin
      hi_off = '0;
    end else if (hi_diff >= IDX_W'(WORD_BITS)) begin
      hi_off = OFF_W'(WORD_BITS);
    end else begin
      hi_off = OFF_W'(hi_diff);
    end
    for (int j = 0; j < WORD_BITS; j++) begin
      run_mask[j] = (OFF_W'(j) >= lo_off) && (OFF_W'(j) < hi_off);
    end
  end

  // Write port: zero sweep after reset, else read-modify-write of the run
  always_comb begin
    if (state_r == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = issue_w_r[ADDR_W-1:0];
      mem_wdata = '0;
    end else begin
      mem_we    = (state_r == S_APPLY) && pv_r;
      mem_waddr = proc_w_r;
      if (op_r == bpra_pkg::OP_FREE) begin
        mem_wdata = rd_data_r | run_mask;
      end else begin
        mem_wdata = rd_data_r & ~run_mask;
      end
    end
  end

  // Bitmap RAM with registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= map_mem[mem_raddr];
    end
  end

  // Sequencer: sweep, scan, apply, respond
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      issue_w_r    <= '0;
      pv_r         <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      // Drop a taken beat; the response step reloads the register itself
      if (out_tvalid_r && out_tready && (state_r != S_RESP)) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          if (issue_w_r == WCNT_W'(MAP_WORDS - 1)) begin
            issue_w_r <= '0;
            state_r   <= S_IDLE;
          end else begin
            issue_w_r <= issue_w_r + WCNT_W'(1);
          end
        end

        S_IDLE: begin
          if (in_acc) begin
            op_r         <= in_op;
            count_r      <= in_count;
            issue_w_r    <= '0;
            issue_base_r <= '0;
            pv_r         <= 1'b0;
            run_r        <= '0;
            cs_w_r       <= '0;
            cs_base_r    <= '0;
            if (in_op == bpra_pkg::OP_FREE) begin
              lo_r     <= free_lo;
              hi_r     <= free_hi;
              status_r <= bpra_pkg::STATUS_DONE;
              if (free_lo < free_hi) begin
                state_r <= S_APPLY;
              end else begin
                state_r <= S_RESP;
              end
            end else if (in_count == '0) begin
              status_r <= bpra_pkg::STATUS_ZERO_COUNT;
              state_r  <= S_RESP;
            end else begin
              status_r <= bpra_pkg::STATUS_DONE;
              state_r  <= S_SCAN;
            end
          end
        end

        S_SCAN: begin
          proc_w_r    <= issue_w_r[ADDR_W-1:0];
          proc_base_r <= issue_base_r;
          if (pv_r && scan.found) begin
            // Restart the pass at the word where the run begins
            lo_r     <= hit_first;
            hi_r     <= hit_first + IDX_W'(count_r);
            pv_r     <= 1'b0;
            status_r <= bpra_pkg::STATUS_DONE;
            state_r  <= S_APPLY;
            if (scan.start_here) begin
              issue_w_r    <= WCNT_W'(proc_w_r);
              issue_base_r <= proc_base_r;
            end else begin
              issue_w_r    <= cs_w_r;
              issue_base_r <= cs_base_r;
            end
          end else begin
            pv_r <= issue_ok;
            if (issue_ok) begin
              issue_w_r    <= issue_w_r + WCNT_W'(1);
              issue_base_r <= issue_base_r + IDX_W'(WORD_BITS);
            end
            if (pv_r) begin
              // Carry the open run and the word where it began
              run_r <= scan.run_out;
              if (!rd_data_r[WORD_BITS-1]) begin
                cs_w_r    <= WCNT_W'(proc_w_r) + WCNT_W'(1);
                cs_base_r <= proc_base_r + IDX_W'(WORD_BITS);
              end else if (scan.any_zero) begin
                cs_w_r    <= WCNT_W'(proc_w_r);
                cs_base_r <= proc_base_r;
              end
              if (proc_w_r == ADDR_W'(MAP_WORDS - 1)) begin
                status_r <= bpra_pkg::STATUS_NO_SPACE;
                state_r  <= S_RESP;
              end
            end
          end
        end

        S_APPLY: begin
          pv_r        <= issue_ok;
          proc_w_r    <= issue_w_r[ADDR_W-1:0];
          proc_base_r <= issue_base_r;
          if (issue_ok) begin
            issue_w_r    <= issue_w_r + WCNT_W'(1);
            issue_base_r <= issue_base_r + IDX_W'(WORD_BITS);
          end
          if (!issue_ok && !pv_r) begin
            state_r <= S_RESP;
          end
        end

        S_RESP: begin
          // Hold until the output register is free
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_status_r <= status_r;
            if ((op_r == bpra_pkg::OP_ALLOC) && (status_r == bpra_pkg::STATUS_DONE)) begin
              out_run_r <= PAGE_W'(IDX_W'(FIRST_PAGE) + lo_r);
            end else begin
              out_run_r <= '0;
            end
            state_r <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(bpra_pkg::OUT_DATA_W - PAGE_W){1'b0}}, out_run_r};
  assign out_tuser  = out_status_r;

`ifndef NO_ASSERTIONS
  // The reset sweep never competes with a bitmap read
  a_clear_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !mem_re)
    else $error("bitmap read during reset sweep");

  // Read-modify-write never reads the word it is writing back
  a_rmw_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_APPLY && mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("bitmap read and write hit the same word");

  // A pending result is never overwritten by the next response
  a_resp_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP && out_tvalid_r && !out_tready) |=> (state_r == S_RESP))
    else $error("response left while output register was full");

  // A failed or zero-count allocate reports page zero
  a_fail_zero_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && (out_status_r == bpra_pkg::STATUS_NO_SPACE ||
                      out_status_r == bpra_pkg::STATUS_ZERO_COUNT)) |-> (out_run_r == '0))
    else $error("failed allocate carries a run start");
`endif

endmodule
